@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/kda_pkg.sv @@
// ----------------------------------------------------------------------------
// kda_pkg
// Types and constants for the key debounce and auto-repeat unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kda_pkg;

	localparam int CNT_W     = 18;
	localparam int DLY_W     = 16;
	localparam int LIM_W     = 8;
	localparam int KEY_IDX_W = 2;
	localparam int MASK_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_INITIAL_DELAY     = 2'd0;
	localparam cfg_idx_t CFG_SLOW_INTERVAL     = 2'd1;
	localparam cfg_idx_t CFG_FAST_INTERVAL     = 2'd2;
	localparam cfg_idx_t CFG_SLOW_REPEAT_LIMIT = 2'd3;

	localparam logic [DLY_W-1:0] RST_INITIAL_DELAY     = 16'd500;
	localparam logic [DLY_W-1:0] RST_SLOW_INTERVAL     = 16'd100;
	localparam logic [DLY_W-1:0] RST_FAST_INTERVAL     = 16'd20;
	localparam logic [LIM_W-1:0] RST_SLOW_REPEAT_LIMIT = 8'd5;

	localparam logic FUNC_SCAN  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef struct packed {
		logic [DLY_W-1:0] initial_delay;
		logic [DLY_W-1:0] slow_interval;
		logic [DLY_W-1:0] fast_interval;
		logic [LIM_W-1:0] slow_repeat_limit;
	} cfg_t;

	typedef struct packed {
		logic                 func;
		logic [KEY_IDX_W-1:0] key_index;
		logic                 pin_level;
	} scan_t;

endpackage

`default_nettype wire

@@ design/kda_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// kda_cfg_regs
// Configuration register file: delay, intervals and slow repeat limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kda_cfg_regs
	import kda_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire cfg_idx_t             wr_index,
	input  wire logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_delay     <= RST_INITIAL_DELAY;
			cfg_q.slow_interval     <= RST_SLOW_INTERVAL;
			cfg_q.fast_interval     <= RST_FAST_INTERVAL;
			cfg_q.slow_repeat_limit <= RST_SLOW_REPEAT_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_INITIAL_DELAY:     cfg_q.initial_delay     <= wr_data[DLY_W-1:0];
				CFG_SLOW_INTERVAL:     cfg_q.slow_interval     <= wr_data[DLY_W-1:0];
				CFG_FAST_INTERVAL:     cfg_q.fast_interval     <= wr_data[DLY_W-1:0];
				CFG_SLOW_REPEAT_LIMIT: cfg_q.slow_repeat_limit <= wr_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ design/kda_scan_core.sv @@
// ----------------------------------------------------------------------------
// kda_scan_core
// Per-key debounce lanes with hold counters and auto-repeat, plus event bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kda_scan_core
	import kda_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire scan_t             item,
	input  wire cfg_t              cfg,
	output logic [MASK_W-1:0]      mask_next
);

	logic [NUM_KEYS-1:0]        event_q;
	logic [NUM_KEYS-1:0]        set_ev;
	logic [NUM_KEYS-1:0]        ev_next;
	logic [NUM_KEYS+MASK_W-1:0] ev_pad;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic             first_q, conf_q, first_d, conf_d;
		logic             hit, pressed, fast, set_d;
		logic [CNT_W-1:0] hold_q, hold_d, hold_inc, thresh;
		logic [LIM_W-1:0] srep_q, srep_d;
		logic [DLY_W-1:0] ivl;

		assign hit      = (item.func == FUNC_SCAN) && (int'(item.key_index) == k);
		assign pressed  = (item.pin_level == 1'b0);
		assign fast     = srep_q > cfg.slow_repeat_limit;
		assign ivl      = fast ? cfg.fast_interval : cfg.slow_interval;
		assign hold_inc = hold_q + CNT_W'(1);
		assign thresh   = CNT_W'(cfg.initial_delay) + CNT_W'(ivl);

		always_comb begin
			first_d = first_q;
			conf_d  = conf_q;
			hold_d  = hold_q;
			srep_d  = srep_q;
			set_d   = 1'b0;
			if (pressed) begin
				priority if (first_q) begin
					first_d = 1'b0;
				end else if (conf_q) begin
					conf_d = 1'b0;
					hold_d = '0;
				end else begin
					// held: count scans, repeat past the threshold
					hold_d = hold_inc;
					if (hold_inc > thresh) begin
						hold_d = CNT_W'(cfg.initial_delay);
						set_d  = 1'b1;
						if (!fast) begin
							srep_d = srep_q + LIM_W'(1);
						end
					end
				end
			end else begin
				priority if (!first_q) begin
					first_d = 1'b1;
				end else if (!conf_q) begin
					// release confirmed
					conf_d = 1'b1;
					set_d  = 1'b1;
					hold_d = '0;
					srep_d = '0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				first_q <= 1'b1;
				conf_q  <= 1'b1;
				hold_q  <= '0;
				srep_q  <= '0;
			end else if (step && hit) begin
				first_q <= first_d;
				conf_q  <= conf_d;
				hold_q  <= hold_d;
				srep_q  <= srep_d;
			end
		end

		assign set_ev[k] = hit && set_d;
	end

	assign ev_next = (item.func == FUNC_CLEAR) ? '0 : (event_q | set_ev);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_q <= '0;
		end else if (step) begin
			event_q <= ev_next;
		end
	end

	assign ev_pad    = {{MASK_W{1'b0}}, ev_next};
	assign mask_next = ev_pad[MASK_W-1:0];

endmodule

`default_nettype wire

@@ design/key_debounce_autorepeat_unit.sv @@
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_unit
// Debounce and auto-repeat for multiplexed keys, one key per scan word.
// ----------------------------------------------------------------------------
// Channel  Handshake              Payload
// in       in_valid / in_ready    func, key_index, pin_level
// out      out_valid / out_ready  event_mask
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while the result is not stalled. A word is taken
// into the input register, then the key lane update writes the result register.
// Reset loads the default registers, puts all keys in idle, clears events.
// A stalled result holds; one more word waits in the input register before
// in_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_autorepeat_unit
	import kda_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 func,
	input  wire logic [KEY_IDX_W-1:0] key_index,
	input  wire logic                 pin_level,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [MASK_W-1:0]         event_mask,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire cfg_idx_t             cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t              cfg;
	scan_t             item_s1;
	logic              valid_s1;
	logic              advance;
	logic              out_valid_q;
	logic [MASK_W-1:0] mask_q;
	logic [MASK_W-1:0] mask_next;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	kda_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{func: func, key_index: key_index, pin_level: pin_level};
		end
	end

	kda_scan_core #(
		.NUM_KEYS (NUM_KEYS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.mask_next (mask_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_q <= mask_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_mask = mask_q;

endmodule

`default_nettype wire

@@ design/kda_checker.sv @@
// ----------------------------------------------------------------------------
// kda_checker
// Port-level checks for the key debounce and auto-repeat unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kda_checker
	import kda_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [MASK_W-1:0] event_mask
);

	`ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "result valid during reset")
	`ASSERT_CLK(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(event_mask), "stalled word changed")
	`ASSERT_CLK(a_no_ghost_keys, out_valid |-> ((event_mask >> NUM_KEYS) == '0), "event on absent key")
	`ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with output empty")
	`ASSERT_CLK(a_result_follows, in_valid && in_ready && !out_valid |-> ##2 out_valid, "word produced no result")

endmodule

bind key_debounce_autorepeat_unit kda_checker #(.NUM_KEYS(NUM_KEYS)) u_kda_checker (.*);

`default_nettype wire
